@@ rtl/lorenz_euler_integrator_macros.svh @@
// Assertion macros for the Lorenz Euler integrator
`ifndef LORENZ_EULER_INTEGRATOR_MACROS_SVH
`define LORENZ_EULER_INTEGRATOR_MACROS_SVH

// check that ante implies cons in the same cycle
`define LEI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// check that ante implies cons in the next cycle
`define LEI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lei_pkg.sv @@
// Types, constants and microcode program of the Lorenz Euler integrator
package lei_pkg;

  localparam int FRAC_BITS   = 20;
  localparam int MAX_POINTS  = 65536;
  localparam int DATA_W      = 32;
  localparam int OP_W        = DATA_W + 1;
  localparam int PROD_W      = 2 * OP_W;
  localparam int IDX_W       = 16;
  localparam int LEN_W       = 17;
  localparam int DT_W        = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_CAP_INT = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  localparam logic signed [DATA_W-1:0] SIGMA_RST      = 32'sd10485760;
  localparam logic signed [DATA_W-1:0] RHO_RST        = 32'sd29360128;
  localparam logic signed [DATA_W-1:0] BETA_RST       = 32'sd2796203;
  localparam logic        [DT_W-1:0]   TIME_STEP_RST  = 31'd10486;
  localparam logic        [LEN_W-1:0]  NUM_POINTS_RST = 17'd10000;

  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA      = 3'd0,
    REG_RHO        = 3'd1,
    REG_BETA       = 3'd2,
    REG_TIME_STEP  = 3'd3,
    REG_NUM_POINTS = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] start_time;
    logic signed [DATA_W-1:0] start_x;
    logic signed [DATA_W-1:0] start_y;
    logic signed [DATA_W-1:0] start_z;
  } in_item_t;

  typedef struct packed {
    logic        [IDX_W-1:0]  point_index;
    logic signed [DATA_W-1:0] time_out;
    logic signed [DATA_W-1:0] x_out;
    logic signed [DATA_W-1:0] y_out;
    logic signed [DATA_W-1:0] z_out;
    logic                     last;
    logic                     overflow;
    logic                     beyond_end;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_DISPATCH,
    SEQ_END
  } seq_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_SIGMA,
    A_X,
    A_BETA,
    A_FX,
    A_FY,
    A_FZ
  } asel_e;

  typedef enum logic [2:0] {
    B_NONE,
    B_YMX,
    B_RMZ,
    B_Y,
    B_Z,
    B_DT
  } bsel_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_FX,
    WB_FY,
    WB_ACC,
    WB_FZ,
    WB_NX,
    WB_NY,
    WB_NZ,
    WB_LOAD,
    WB_BEYOND
  } wb_e;

  typedef struct packed {
    seq_e  seq;
    asel_e a_sel;
    bsel_e b_sel;
    wb_e   wb;
  } uop_t;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] PROG_LEN    = 4'd11;
  localparam logic [UPC_W-1:0] UA_DISPATCH = 4'd0;
  localparam logic [UPC_W-1:0] UA_STEP     = 4'd1;
  localparam logic [UPC_W-1:0] UA_LOAD     = 4'd9;
  localparam logic [UPC_W-1:0] UA_BEYOND   = 4'd10;

  function automatic uop_t ucode(input logic [UPC_W-1:0] addr);
    uop_t u;
    case (addr)
      UA_DISPATCH: u = '{SEQ_DISPATCH, A_NONE,  B_NONE, WB_NONE};
      4'd1:        u = '{SEQ_NEXT,     A_SIGMA, B_YMX,  WB_NONE};
      4'd2:        u = '{SEQ_NEXT,     A_X,     B_RMZ,  WB_FX};
      4'd3:        u = '{SEQ_NEXT,     A_X,     B_Y,    WB_FY};
      4'd4:        u = '{SEQ_NEXT,     A_BETA,  B_Z,    WB_ACC};
      4'd5:        u = '{SEQ_NEXT,     A_FX,    B_DT,   WB_FZ};
      4'd6:        u = '{SEQ_NEXT,     A_FY,    B_DT,   WB_NX};
      4'd7:        u = '{SEQ_NEXT,     A_FZ,    B_DT,   WB_NY};
      4'd8:        u = '{SEQ_END,      A_NONE,  B_NONE, WB_NZ};
      UA_LOAD:     u = '{SEQ_END,      A_NONE,  B_NONE, WB_LOAD};
      UA_BEYOND:   u = '{SEQ_END,      A_NONE,  B_NONE, WB_BEYOND};
      default:     u = '{SEQ_END,      A_NONE,  B_NONE, WB_NONE};
    endcase
    return u;
  endfunction

  function automatic sat_t sat32(input prod_t v);
    sat_t r;
    r.ovf = !((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1]));
    if (r.ovf) begin
      r.val = v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/lei_if.sv @@
// Valid/ready channel interfaces for input items and result items
interface lei_in_if;
  logic               valid;
  logic               ready;
  lei_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lei_out_if;
  logic               valid;
  logic               ready;
  lei_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lorenz_euler_integrator.sv @@
// Lorenz Euler integrator: one forward Euler step per step item, run by a microcoded sequencer
// An item is taken in only while the block is idle, so each load or step item runs its
// microcode before the next one is taken in: a step runs nine microcode words that pass seven
// products through one shared 33 by 33 signed multiplier with a registered product, then the
// result enters an output register that holds it until taken; a new item is accepted while it
// waits. An item that reaches its last microcode word while the previous result still waits
// holds that word, and the product with it, until that result is taken. A step at or past the
// last point, or a load, returns after two microcode words. Coefficients, dt and the trajectory
// length come from a write port (index 0 sigma, 1 rho, 2 beta, 3 time_step, 4 num_points) that
// the user must write only while the block is idle; the block itself does not enforce this.
module lorenz_euler_integrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lei_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lei_pkg::DATA_W-1:0]          cfg_wdata_i,
  lei_in_if.sink                              in_i,
  lei_out_if.source                           out_o
);

`include "lorenz_euler_integrator_macros.svh"

  logic signed [lei_pkg::DATA_W-1:0] sigma_q, rho_q, beta_q;
  logic        [lei_pkg::DT_W-1:0]   dt_q;
  logic        [lei_pkg::LEN_W-1:0]  npts_q;

  logic signed [lei_pkg::DATA_W-1:0] cur_x_q, cur_y_q, cur_z_q, cur_time_q;
  logic signed [lei_pkg::DATA_W-1:0] cur_x_d, cur_y_d, cur_z_d, cur_time_d;
  logic        [lei_pkg::IDX_W-1:0]  cur_index_q, cur_index_d;

  logic signed [lei_pkg::DATA_W-1:0] fx_q, fy_q, fz_q;
  logic signed [lei_pkg::DATA_W-1:0] fx_d, fy_d, fz_d;
  lei_pkg::prod_t                    acc_q, acc_d, prod_q, prod_d;
  logic                              ovf_q, ovf_d;
  lei_pkg::in_item_t                 item_q;

  lei_pkg::state_e                   state_q, state_d;
  logic        [lei_pkg::UPC_W-1:0]  upc_q, upc_d;
  lei_pkg::uop_t                     uop;
  logic                              run, stall, adv, in_fire, out_fire, end_fire;

  lei_pkg::out_item_t                out_q, out_d;
  logic                              out_valid_q, out_valid_d;

  logic        [lei_pkg::LEN_W-1:0]  eff_len, new_succ, cur_succ;
  logic                              at_end;

  lei_pkg::op_t                      op_a, op_b;
  lei_pkg::prod_t                    sh, fz_diff, sat_in;
  lei_pkg::sat_t                     sat_r, sat_t_r;
  lei_pkg::prod_t                    dt_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= lei_pkg::SIGMA_RST;
      rho_q   <= lei_pkg::RHO_RST;
      beta_q  <= lei_pkg::BETA_RST;
      dt_q    <= lei_pkg::TIME_STEP_RST;
      npts_q  <= lei_pkg::NUM_POINTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lei_pkg::REG_SIGMA:      sigma_q <= cfg_wdata_i;
        lei_pkg::REG_RHO:        rho_q   <= cfg_wdata_i;
        lei_pkg::REG_BETA:       beta_q  <= cfg_wdata_i;
        lei_pkg::REG_TIME_STEP:  dt_q    <= cfg_wdata_i[lei_pkg::DT_W-1:0];
        lei_pkg::REG_NUM_POINTS: npts_q  <= cfg_wdata_i[lei_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = (npts_q == '0) ? lei_pkg::LEN_W'(1) : npts_q;
    if (eff_len > lei_pkg::LEN_CAP) begin
      eff_len = lei_pkg::LEN_CAP;
    end
    cur_succ = {1'b0, cur_index_q} + lei_pkg::LEN_W'(1);
    at_end   = (cur_succ >= eff_len);
  end

  // handshake and sequencer control
  assign run      = (state_q == lei_pkg::ST_RUN);
  assign uop      = lei_pkg::ucode(upc_q);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign stall    = run && (uop.seq == lei_pkg::SEQ_END) && out_valid_q && !out_o.ready;
  assign adv      = run && !stall;
  assign end_fire = adv && (uop.seq == lei_pkg::SEQ_END);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lei_pkg::ST_IDLE: if (in_fire) state_d = lei_pkg::ST_RUN;
      lei_pkg::ST_RUN:  if (end_fire) state_d = lei_pkg::ST_IDLE;
      default:          state_d = lei_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == lei_pkg::ST_IDLE);
    upc_d      = upc_q;
    if (in_fire) begin
      upc_d = lei_pkg::UA_DISPATCH;
    end else if (adv) begin
      case (uop.seq)
        lei_pkg::SEQ_DISPATCH: begin
          if (item_q.cmd == lei_pkg::CMD_LOAD) begin
            upc_d = lei_pkg::UA_LOAD;
          end else if (at_end) begin
            upc_d = lei_pkg::UA_BEYOND;
          end else begin
            upc_d = lei_pkg::UA_STEP;
          end
        end
        lei_pkg::SEQ_NEXT: upc_d = upc_q + lei_pkg::UPC_W'(1);
        default:           upc_d = upc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lei_pkg::ST_IDLE;
      upc_q   <= lei_pkg::UA_DISPATCH;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.data;
    end
  end

  // multiplier operands
  always_comb begin
    case (uop.a_sel)
      lei_pkg::A_SIGMA: op_a = lei_pkg::op_t'(sigma_q);
      lei_pkg::A_X:     op_a = lei_pkg::op_t'(cur_x_q);
      lei_pkg::A_BETA:  op_a = lei_pkg::op_t'(beta_q);
      lei_pkg::A_FX:    op_a = lei_pkg::op_t'(fx_q);
      lei_pkg::A_FY:    op_a = lei_pkg::op_t'(fy_q);
      lei_pkg::A_FZ:    op_a = lei_pkg::op_t'(fz_q);
      default:          op_a = '0;
    endcase
    case (uop.b_sel)
      lei_pkg::B_YMX: op_b = lei_pkg::op_t'(cur_y_q) - lei_pkg::op_t'(cur_x_q);
      lei_pkg::B_RMZ: op_b = lei_pkg::op_t'(rho_q) - lei_pkg::op_t'(cur_z_q);
      lei_pkg::B_Y:   op_b = lei_pkg::op_t'(cur_y_q);
      lei_pkg::B_Z:   op_b = lei_pkg::op_t'(cur_z_q);
      lei_pkg::B_DT:  op_b = lei_pkg::op_t'({2'b00, dt_q});
      default:        op_b = '0;
    endcase
    prod_d = lei_pkg::prod_t'(op_a) * lei_pkg::prod_t'(op_b);
  end

  // writeback: floor shift, add or subtract, saturate
  always_comb begin
    sh      = prod_q >>> lei_pkg::FRAC_BITS;
    fz_diff = acc_q - prod_q;
    dt_ext  = lei_pkg::prod_t'({1'b0, dt_q});
    case (uop.wb)
      lei_pkg::WB_FY: sat_in = sh - lei_pkg::prod_t'(cur_y_q);
      lei_pkg::WB_FZ: sat_in = fz_diff >>> lei_pkg::FRAC_BITS;
      lei_pkg::WB_NX: sat_in = lei_pkg::prod_t'(cur_x_q) + sh;
      lei_pkg::WB_NY: sat_in = lei_pkg::prod_t'(cur_y_q) + sh;
      lei_pkg::WB_NZ: sat_in = lei_pkg::prod_t'(cur_z_q) + sh;
      default:        sat_in = sh;
    endcase
    sat_r   = lei_pkg::sat32(sat_in);
    sat_t_r = lei_pkg::sat32(lei_pkg::prod_t'(cur_time_q) + dt_ext);

    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cur_z_d     = cur_z_q;
    cur_time_d  = cur_time_q;
    cur_index_d = cur_index_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    fz_d        = fz_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    if (adv) begin
      case (uop.wb)
        lei_pkg::WB_FX: begin
          fx_d  = sat_r.val;
          ovf_d = ovf_q | sat_r.ovf;
        end
        lei_pkg::WB_FY: begin
          fy_d  = sat_r.val;
          ovf_d = ovf_q | sat_r.ovf;
        end
        lei_pkg::WB_ACC: acc_d = prod_q;
        lei_pkg::WB_FZ: begin
          fz_d  = sat_r.val;
          ovf_d = ovf_q | sat_r.ovf;
        end
        lei_pkg::WB_NX: begin
          cur_x_d = sat_r.val;
          ovf_d   = ovf_q | sat_r.ovf;
        end
        lei_pkg::WB_NY: begin
          cur_y_d = sat_r.val;
          ovf_d   = ovf_q | sat_r.ovf;
        end
        lei_pkg::WB_NZ: begin
          cur_z_d     = sat_r.val;
          cur_time_d  = sat_t_r.val;
          cur_index_d = cur_index_q + lei_pkg::IDX_W'(1);
          ovf_d       = ovf_q | sat_r.ovf | sat_t_r.ovf;
        end
        lei_pkg::WB_LOAD: begin
          cur_time_d  = item_q.start_time;
          cur_x_d     = item_q.start_x;
          cur_y_d     = item_q.start_y;
          cur_z_d     = item_q.start_z;
          cur_index_d = '0;
        end
        default: ;
      endcase
      if (uop.seq == lei_pkg::SEQ_DISPATCH) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_z_q     <= '0;
      cur_time_q  <= '0;
      cur_index_q <= '0;
      ovf_q       <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_z_q     <= cur_z_d;
      cur_time_q  <= cur_time_d;
      cur_index_q <= cur_index_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    fz_q  <= fz_d;
    acc_q <= acc_d;
    if (!stall) begin
      prod_q <= prod_d;
    end
  end

  // result register
  always_comb begin
    new_succ              = {1'b0, cur_index_d} + lei_pkg::LEN_W'(1);
    out_d.point_index     = cur_index_d;
    out_d.time_out        = cur_time_d;
    out_d.x_out           = cur_x_d;
    out_d.y_out           = cur_y_d;
    out_d.z_out           = cur_z_d;
    out_d.last            = (new_succ == eff_len);
    out_d.overflow        = ovf_d;
    out_d.beyond_end      = (uop.wb == lei_pkg::WB_BEYOND);
    out_valid_d           = out_valid_q;
    if (end_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `LEI_ASSERT_IMP(a_upc_range, run, upc_q < lei_pkg::PROG_LEN, "upc out of range")
  `LEI_ASSERT_IMP(a_beyond_no_ovf, out_valid_q && out_q.beyond_end, !out_q.overflow,
                  "overflow on beyond-end result")
  `LEI_ASSERT_NXT(a_step_index, adv && (uop.wb == lei_pkg::WB_NZ),
                  cur_index_q == $past(cur_index_q) + lei_pkg::IDX_W'(1),
                  "step did not advance index by one")
  `LEI_ASSERT_NXT(a_load_index, adv && (uop.wb == lei_pkg::WB_LOAD), cur_index_q == '0,
                  "load did not clear index")

endmodule
